[design/sprite_xor_framebuffer_draw_core_assert.svh]
// Assertion macros for the sprite frame buffer core.
`ifndef SPRITE_XOR_FRAMEBUFFER_DRAW_CORE_ASSERT_SVH
`define SPRITE_XOR_FRAMEBUFFER_DRAW_CORE_ASSERT_SVH

`ifndef ASSERT_OFF
`define SXFD_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("sxfd: assertion failed");
`define SXFD_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("sxfd: assertion failed");
`else
`define SXFD_ASSERT_IMP(lbl, ante, cons)
`define SXFD_ASSERT_NXT(lbl, ante, cons)
`endif

`endif

[design/sxfd_pkg.sv]
package sxfd_pkg;

  localparam int DEF_HI_WIDTH  = 128;
  localparam int DEF_HI_HEIGHT = 64;
  localparam int DEF_LO_WIDTH  = 64;
  localparam int DEF_LO_HEIGHT = 32;

  // offset + coordinate + row fits in nine bits
  localparam int SUM_W = 9;
  localparam int RCP_W = 8;
  localparam int SPR_W = 8;

  typedef logic [1:0] opcode_t;
  localparam opcode_t OP_DRAW  = 2'd0;
  localparam opcode_t OP_CLEAR = 2'd1;
  localparam opcode_t OP_READ  = 2'd2;

  typedef logic [1:0] cfg_idx_t;
  localparam cfg_idx_t CFG_HIGH_RES = 2'd0;
  localparam cfg_idx_t CFG_SCROLL_X = 2'd1;
  localparam cfg_idx_t CFG_SCROLL_Y = 2'd2;

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_RED  = 4'b0010,
    ST_RD   = 4'b0100,
    ST_WR   = 4'b1000
  } state_t;

  typedef struct packed {
    logic load;
    logic reduce;
    logic mask;
  } addr_ctl_t;

  typedef struct packed {
    logic rd;
    logic wr;
    logic clr;
  } mem_ctl_t;

endpackage

[design/sprite_xor_framebuffer_draw_core.sv]
// Monochrome XOR frame buffer with sprite row draw, clear and pixel read.
// Input channel: an item (in_opcode and its fields) is taken at a rising
// edge with start high and busy low. Opcode draw XORs one 8-pixel sprite
// row into one buffer line, clear empties the buffer, read returns a pixel.
// Result channel: out_strobe is high for one cycle with out_collision,
// out_pixel and out_done_res; the receiver cannot hold results off.
// Configuration: cfg_we writes register cfg_index (0 high_res, 1 scroll_x,
// 2 scroll_y) from cfg_data; write only while no item is in flight.
// After the accepting edge an item passes the reduce, read and write-back
// states; the result strobe is registered from write-back. Busy is low
// again in write-back, so the next item can be taken there. The states
// hold the coordinate reduction (reciprocal multiply, multiply-subtract)
// and the registered line read; a draw XORs the line and writes it back.
// Reset: the buffer reads as all zero, collision and registers clear, and
// items are taken right after reset with no clearing pass.
module sprite_xor_framebuffer_draw_core import sxfd_pkg::*; #(
  parameter int HI_WIDTH  = DEF_HI_WIDTH,
  parameter int HI_HEIGHT = DEF_HI_HEIGHT,
  parameter int LO_WIDTH  = DEF_LO_WIDTH,
  parameter int LO_HEIGHT = DEF_LO_HEIGHT
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       start,
  output logic       busy,
  input  logic [1:0] in_opcode,
  input  logic [7:0] in_x_coord,
  input  logic [7:0] in_y_coord,
  input  logic [3:0] in_row_index,
  input  logic [7:0] in_sprite_row,
  input  logic       in_last_row,
  output logic       out_strobe,
  output logic       out_collision,
  output logic       out_pixel,
  output logic       out_done_res,
  input  logic       cfg_we,
  input  logic [1:0] cfg_index,
  input  logic [6:0] cfg_data
);

  `include "sprite_xor_framebuffer_draw_core_assert.svh"

  localparam int FB_COLS  = (HI_WIDTH > LO_WIDTH) ? HI_WIDTH : LO_WIDTH;
  localparam int FB_LINES = (HI_HEIGHT > LO_HEIGHT) ? HI_HEIGHT : LO_HEIGHT;
  localparam int CW = $clog2(FB_COLS);
  localparam int LW = $clog2(FB_LINES);

  state_t     state_r, state_nxt;
  logic       hr_r;
  logic [6:0] sx_r;
  logic [5:0] sy_r;
  opcode_t    op_r;
  logic       row0_r, last_r;
  logic       acc_r, acc_nxt;
  logic       out_strobe_r, out_coll_r, out_pix_r, out_done_r;
  logic       coll_nxt, pix_nxt, done_nxt;

  logic             accept;
  logic [SUM_W-1:0] sum_x, sum_y;
  addr_ctl_t        actl;
  mem_ctl_t         mctl;
  logic [CW-1:0]    col;
  logic [LW-1:0]    line;
  logic [FB_COLS-1:0] mask, word, new_word;
  logic             hit;

  assign busy   = (state_r == ST_RED) || (state_r == ST_RD);
  assign accept = start && !busy;

  assign sum_x = SUM_W'(sx_r) + SUM_W'(in_x_coord);
  assign sum_y = SUM_W'(sy_r) + SUM_W'(in_y_coord) +
                 ((in_opcode == OP_DRAW) ? SUM_W'(in_row_index) : '0);

  assign actl.load   = accept;
  assign actl.reduce = (state_r == ST_RED);
  assign actl.mask   = (state_r == ST_RD);

  assign mctl.rd  = (state_r == ST_RD);
  assign mctl.wr  = (state_r == ST_WR) && (op_r == OP_DRAW);
  assign mctl.clr = (state_r == ST_WR) && (op_r == OP_CLEAR);

  sxfd_addr #(
    .HI_WIDTH  (HI_WIDTH),
    .HI_HEIGHT (HI_HEIGHT),
    .LO_WIDTH  (LO_WIDTH),
    .LO_HEIGHT (LO_HEIGHT),
    .FB_COLS   (FB_COLS),
    .FB_LINES  (FB_LINES)
  ) u_addr (
    .clk    (clk),
    .ctl    (actl),
    .hr     (hr_r),
    .sum_x  (sum_x),
    .sum_y  (sum_y),
    .sprite (in_sprite_row),
    .col    (col),
    .line   (line),
    .mask   (mask)
  );

  sxfd_mem #(
    .FB_COLS  (FB_COLS),
    .FB_LINES (FB_LINES)
  ) u_mem (
    .clk     (clk),
    .rst_n   (rst_n),
    .ctl     (mctl),
    .addr    (line),
    .wr_data (new_word),
    .rd_word (word)
  );

  assign new_word = word ^ mask;
  assign hit      = |(word & mask);

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: if (accept) state_nxt = ST_RED;
      ST_RED:  state_nxt = ST_RD;
      ST_RD:   state_nxt = ST_WR;
      ST_WR:   state_nxt = accept ? ST_RED : ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    acc_nxt  = acc_r;
    coll_nxt = 1'b0;
    pix_nxt  = 1'b0;
    done_nxt = 1'b0;
    if (state_r == ST_WR) begin
      unique case (op_r)
        OP_DRAW: begin
          acc_nxt  = (acc_r & ~row0_r) | hit;
          coll_nxt = acc_nxt;
          done_nxt = last_r;
        end
        OP_CLEAR: done_nxt = 1'b1;
        OP_READ: begin
          pix_nxt  = word[col];
          done_nxt = 1'b1;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      hr_r         <= 1'b0;
      sx_r         <= '0;
      sy_r         <= '0;
      acc_r        <= 1'b0;
      out_strobe_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      acc_r        <= acc_nxt;
      out_strobe_r <= (state_r == ST_WR);
      if (cfg_we) begin
        unique case (cfg_index)
          CFG_HIGH_RES: hr_r <= cfg_data[0];
          CFG_SCROLL_X: sx_r <= cfg_data;
          CFG_SCROLL_Y: sy_r <= cfg_data[5:0];
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      op_r   <= in_opcode;
      row0_r <= (in_row_index == '0);
      last_r <= in_last_row;
    end
    out_coll_r <= coll_nxt;
    out_pix_r  <= pix_nxt;
    out_done_r <= done_nxt;
  end

  assign out_strobe    = out_strobe_r;
  assign out_collision = out_coll_r;
  assign out_pixel     = out_pix_r;
  assign out_done_res  = out_done_r;

  `SXFD_ASSERT_NXT(a_accept_red, accept, state_r == ST_RED)
  `SXFD_ASSERT_NXT(a_wr_strobe, state_r == ST_WR, out_strobe)
  `SXFD_ASSERT_IMP(a_strobe_src, out_strobe, $past(state_r == ST_WR))
  `SXFD_ASSERT_IMP(a_coll_draw, out_strobe && out_collision, $past(op_r == OP_DRAW))
  `SXFD_ASSERT_IMP(a_pix_done, out_strobe && out_pixel, out_done_res)

endmodule

[design/sxfd_addr.sv]
module sxfd_addr import sxfd_pkg::*; #(
  parameter int HI_WIDTH  = DEF_HI_WIDTH,
  parameter int HI_HEIGHT = DEF_HI_HEIGHT,
  parameter int LO_WIDTH  = DEF_LO_WIDTH,
  parameter int LO_HEIGHT = DEF_LO_HEIGHT,
  parameter int FB_COLS   = DEF_HI_WIDTH,
  parameter int FB_LINES  = DEF_HI_HEIGHT
) (
  input  logic                        clk,
  input  addr_ctl_t                   ctl,
  input  logic                        hr,
  input  logic [SUM_W-1:0]            sum_x,
  input  logic [SUM_W-1:0]            sum_y,
  input  logic [SPR_W-1:0]            sprite,
  output logic [$clog2(FB_COLS)-1:0]  col,
  output logic [$clog2(FB_LINES)-1:0] line,
  output logic [FB_COLS-1:0]          mask
);

  localparam int CW = $clog2(FB_COLS);
  localparam int LW = $clog2(FB_LINES);
  localparam int PW = SUM_W + RCP_W;
  localparam logic [RCP_W-1:0] RCP_HI_W = RCP_W'((1 << SUM_W) / HI_WIDTH);
  localparam logic [RCP_W-1:0] RCP_LO_W = RCP_W'((1 << SUM_W) / LO_WIDTH);
  localparam logic [RCP_W-1:0] RCP_HI_H = RCP_W'((1 << SUM_W) / HI_HEIGHT);
  localparam logic [RCP_W-1:0] RCP_LO_H = RCP_W'((1 << SUM_W) / LO_HEIGHT);

  logic             hr_r;
  logic [SUM_W-1:0] vx_r, vy_r;
  logic [RCP_W-1:0] qx_r, qy_r;
  logic [SPR_W-1:0] spr_r;
  logic [CW-1:0]    col_r;
  logic [LW-1:0]    line_r;
  logic [FB_COLS-1:0] mask_r, mask_nxt;

  logic [RCP_W-1:0] rcp_x, rcp_y;
  logic [PW-1:0]    prod_x, prod_y, qw_x, qw_y;
  logic [SUM_W-1:0] w_sel, h_sel, rx, ry, cx, cy;

  assign rcp_x  = hr ? RCP_HI_W : RCP_LO_W;
  assign rcp_y  = hr ? RCP_HI_H : RCP_LO_H;
  assign prod_x = PW'(sum_x) * PW'(rcp_x);
  assign prod_y = PW'(sum_y) * PW'(rcp_y);

  assign w_sel = hr_r ? SUM_W'(HI_WIDTH)  : SUM_W'(LO_WIDTH);
  assign h_sel = hr_r ? SUM_W'(HI_HEIGHT) : SUM_W'(LO_HEIGHT);
  assign qw_x  = PW'(qx_r) * PW'(w_sel);
  assign qw_y  = PW'(qy_r) * PW'(h_sel);
  assign rx    = vx_r - qw_x[SUM_W-1:0];
  assign ry    = vy_r - qw_y[SUM_W-1:0];
  assign cx    = (rx >= w_sel) ? rx - w_sel : rx;
  assign cy    = (ry >= h_sel) ? ry - h_sel : ry;

  always_comb begin
    logic [CW:0] ck;
    mask_nxt = '0;
    ck       = '0;
    for (int k = 0; k < SPR_W; k++) begin
      ck = {1'b0, col_r} + (CW+1)'(k);
      if (ck >= (CW+1)'(w_sel)) begin
        ck = ck - (CW+1)'(w_sel);
      end
      if (spr_r[SPR_W-1-k]) begin
        mask_nxt[ck[CW-1:0]] = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      hr_r  <= hr;
      vx_r  <= sum_x;
      vy_r  <= sum_y;
      qx_r  <= prod_x[PW-1:SUM_W];
      qy_r  <= prod_y[PW-1:SUM_W];
      spr_r <= sprite;
    end
    if (ctl.reduce) begin
      col_r  <= cx[CW-1:0];
      line_r <= cy[LW-1:0];
    end
    if (ctl.mask) begin
      mask_r <= mask_nxt;
    end
  end

  assign col  = col_r;
  assign line = line_r;
  assign mask = mask_r;

endmodule

[design/sxfd_mem.sv]
module sxfd_mem import sxfd_pkg::*; #(
  parameter int FB_COLS  = DEF_HI_WIDTH,
  parameter int FB_LINES = DEF_HI_HEIGHT
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  mem_ctl_t                    ctl,
  input  logic [$clog2(FB_LINES)-1:0] addr,
  input  logic [FB_COLS-1:0]          wr_data,
  output logic [FB_COLS-1:0]          rd_word
);

  logic [FB_COLS-1:0]  mem_r [FB_LINES];
  logic [FB_LINES-1:0] vld_r;
  logic [FB_COLS-1:0]  rdata_r;
  logic                rvld_r;

  always_ff @(posedge clk) begin
    if (ctl.wr) begin
      mem_r[addr] <= wr_data;
    end
    if (ctl.rd) begin
      rdata_r <= mem_r[addr];
      rvld_r  <= vld_r[addr];
    end
  end

  // unwritten lines read as cleared
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (ctl.clr) begin
      vld_r <= '0;
    end else if (ctl.wr) begin
      vld_r[addr] <= 1'b1;
    end
  end

  assign rd_word = rvld_r ? rdata_r : '0;

endmodule

[tb/tb_sprite_xor_framebuffer_draw_core.sv]
`timescale 1ns / 100ps

module tb_sprite_xor_framebuffer_draw_core;
  import sxfd_pkg::*;

  localparam opcode_t OP_NOP = 2'd3;
  localparam int FB_COLS = (DEF_HI_WIDTH > DEF_LO_WIDTH) ? DEF_HI_WIDTH : DEF_LO_WIDTH;
  localparam int FB_LINES = (DEF_HI_HEIGHT > DEF_LO_HEIGHT) ? DEF_HI_HEIGHT : DEF_LO_HEIGHT;
  localparam int RAND_ITEMS = 600;
  localparam int N_PHASES = 6;
  localparam int N_DIR = 21;
  localparam int SETTLE_CYCLES = 8;
  localparam int STALL_LIMIT = 2000;
  localparam int MAX_REPORTS = 10;

  typedef struct packed {
    opcode_t    op;
    logic [7:0] x;
    logic [7:0] y;
    logic [3:0] row;
    logic [7:0] bits;
    logic       last;
  } fb_cmd_t;

  typedef struct packed {
    logic coll;
    logic pix;
    logic done;
  } fb_res_t;

  typedef struct packed {
    fb_cmd_t cmd;
    logic    fixed;
    fb_res_t res;
  } dir_row_t;

  logic       clk;
  logic       rst_n;
  logic       start;
  logic       busy;
  logic [1:0] in_opcode;
  logic [7:0] in_x_coord;
  logic [7:0] in_y_coord;
  logic [3:0] in_row_index;
  logic [7:0] in_sprite_row;
  logic       in_last_row;
  logic       out_strobe;
  logic       out_collision;
  logic       out_pixel;
  logic       out_done_res;
  logic       cfg_we;
  logic [1:0] cfg_index;
  logic [6:0] cfg_data;

  sprite_xor_framebuffer_draw_core u_top (
    .clk           (clk),
    .rst_n         (rst_n),
    .start         (start),
    .busy          (busy),
    .in_opcode     (in_opcode),
    .in_x_coord    (in_x_coord),
    .in_y_coord    (in_y_coord),
    .in_row_index  (in_row_index),
    .in_sprite_row (in_sprite_row),
    .in_last_row   (in_last_row),
    .out_strobe    (out_strobe),
    .out_collision (out_collision),
    .out_pixel     (out_pixel),
    .out_done_res  (out_done_res),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  bit         fb_px [FB_COLS][FB_LINES];
  logic       m_hr;
  logic [6:0] m_sx;
  logic [5:0] m_sy;
  logic       m_coll;
  fb_res_t    pending_res [$];
  fb_res_t    head_res;
  int         err_cnt;
  int         stall_cnt;
  int         gap_pct;
  dir_row_t   dir_tab [N_DIR];

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  function automatic fb_res_t xor_draw(input fb_cmd_t c);
    fb_res_t r;
    int      w;
    int      h;
    int      col;
    int      line;
    int      k;
    r = '0;
    w = m_hr ? DEF_HI_WIDTH : DEF_LO_WIDTH;
    h = m_hr ? DEF_HI_HEIGHT : DEF_LO_HEIGHT;
    case (c.op)
      OP_DRAW: begin
        line = (int'(m_sy) + int'(c.y) + int'(c.row)) % h;
        if (c.row == 4'd0) m_coll = 1'b0;
        for (k = 0; k < 8; k++) begin
          if (c.bits[7-k]) begin
            col = (int'(m_sx) + int'(c.x) + k) % w;
            if (fb_px[col][line]) m_coll = 1'b1;
            fb_px[col][line] = ~fb_px[col][line];
          end
        end
        r.coll = m_coll;
        r.done = c.last;
      end
      OP_CLEAR: begin
        foreach (fb_px[i, j]) fb_px[i][j] = 1'b0;
        r.done = 1'b1;
      end
      OP_READ: begin
        col = (int'(m_sx) + int'(c.x)) % w;
        line = (int'(m_sy) + int'(c.y)) % h;
        r.pix = fb_px[col][line];
        r.done = 1'b1;
      end
      default: begin
      end
    endcase
    return r;
  endfunction

  task automatic issue(input fb_cmd_t c, input logic fixed, input fb_res_t fixed_res);
    logic    ready;
    fb_res_t r;
    while ($urandom_range(99) < gap_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start         <= 1'b1;
    in_opcode     <= c.op;
    in_x_coord    <= c.x;
    in_y_coord    <= c.y;
    in_row_index  <= c.row;
    in_sprite_row <= c.bits;
    in_last_row   <= c.last;
    ready = 1'b0;
    while (!ready) begin
      @(negedge clk);
      ready = (busy === 1'b0);
      if (ready) begin
        r = xor_draw(c);
        pending_res.insert(pending_res.size(), fixed ? fixed_res : r);
      end
      @(posedge clk);
    end
  endtask

  task automatic settle();
    start <= 1'b0;
    while (pending_res.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_regs(input logic hr, input logic [6:0] sx, input logic [5:0] sy);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_HIGH_RES;
    cfg_data  <= {6'd0, hr};
    @(posedge clk);
    cfg_index <= CFG_SCROLL_X;
    cfg_data  <= sx;
    @(posedge clk);
    cfg_index <= CFG_SCROLL_Y;
    cfg_data  <= {1'b0, sy};
    @(posedge clk);
    cfg_we <= 1'b0;
    m_hr = hr;
    m_sx = sx;
    m_sy = sy;
  endtask

  // result check
  always @(posedge clk) begin
    if (rst_n && out_strobe) begin
      if (pending_res.size() == 0) begin
        err_cnt++;
        if (err_cnt <= MAX_REPORTS)
          $display("%0t: result with none pending: coll=%b pix=%b done=%b",
                   $realtime, out_collision, out_pixel, out_done_res);
      end else begin
        head_res = pending_res.pop_front();
        if (out_collision !== head_res.coll || out_pixel !== head_res.pix ||
            out_done_res !== head_res.done) begin
          err_cnt++;
          if (err_cnt <= MAX_REPORTS)
            $display("%0t: mismatch coll=%b/%b pix=%b/%b done=%b/%b (got/exp)",
                     $realtime, out_collision, head_res.coll, out_pixel, head_res.pix,
                     out_done_res, head_res.done);
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_strobe) begin
      stall_cnt <= 0;
    end else if (stall_cnt >= STALL_LIMIT) begin
      $display("** sprite_xor_framebuffer_draw_core: FAILED **");
      $finish;
    end else begin
      stall_cnt <= stall_cnt + 1;
    end
  end

  initial begin
    fb_cmd_t    c;
    int         sent;
    int         pick;
    int         n;
    logic [7:0] sp_x;
    logic [7:0] sp_y;
    rst_n         = 1'b0;
    start         = 1'b0;
    in_opcode     = OP_DRAW;
    in_x_coord    = '0;
    in_y_coord    = '0;
    in_row_index  = '0;
    in_sprite_row = '0;
    in_last_row   = 1'b0;
    cfg_we        = 1'b0;
    cfg_index     = CFG_HIGH_RES;
    cfg_data      = '0;
    err_cnt       = 0;
    stall_cnt     = 0;
    gap_pct       = 0;
    m_hr          = 1'b0;
    m_sx          = '0;
    m_sy          = '0;
    m_coll        = 1'b0;
    sp_x          = '0;
    sp_y          = '0;
    foreach (fb_px[i, j]) fb_px[i][j] = 1'b0;

    dir_tab = '{
      '{'{OP_READ,  8'd0,   8'd0,   4'd0,  8'h00, 1'b0}, 1'b1, '{1'b0, 1'b0, 1'b1}},
      '{'{OP_READ,  8'd255, 8'd255, 4'd15, 8'hff, 1'b1}, 1'b1, '{1'b0, 1'b0, 1'b1}},
      '{'{OP_DRAW,  8'd0,   8'd0,   4'd0,  8'hff, 1'b0}, 1'b1, '{1'b0, 1'b0, 1'b0}},
      '{'{OP_READ,  8'd0,   8'd0,   4'd0,  8'h00, 1'b0}, 1'b0, '0},
      '{'{OP_READ,  8'd7,   8'd0,   4'd0,  8'h00, 1'b0}, 1'b0, '0},
      '{'{OP_READ,  8'd8,   8'd0,   4'd0,  8'h00, 1'b0}, 1'b0, '0},
      '{'{OP_DRAW,  8'd0,   8'd0,   4'd0,  8'h80, 1'b1}, 1'b0, '0},
      '{'{OP_READ,  8'd0,   8'd0,   4'd0,  8'h00, 1'b0}, 1'b0, '0},
      '{'{OP_DRAW,  8'd255, 8'd255, 4'd15, 8'hff, 1'b1}, 1'b0, '0},
      '{'{OP_READ,  8'd63,  8'd14,  4'd0,  8'h00, 1'b0}, 1'b0, '0},
      '{'{OP_READ,  8'd255, 8'd14,  4'd0,  8'h00, 1'b0}, 1'b0, '0},
      '{'{OP_DRAW,  8'd60,  8'd31,  4'd1,  8'h01, 1'b0}, 1'b0, '0},
      '{'{OP_DRAW,  8'd60,  8'd31,  4'd1,  8'h00, 1'b1}, 1'b0, '0},
      '{'{OP_NOP,   8'd255, 8'd255, 4'd15, 8'hff, 1'b1}, 1'b1, '{1'b0, 1'b0, 1'b0}},
      '{'{OP_READ,  8'd63,  8'd14,  4'd0,  8'h00, 1'b0}, 1'b0, '0},
      '{'{OP_CLEAR, 8'd255, 8'd255, 4'd15, 8'hff, 1'b1}, 1'b1, '{1'b0, 1'b0, 1'b1}},
      '{'{OP_READ,  8'd63,  8'd14,  4'd0,  8'h00, 1'b0}, 1'b1, '{1'b0, 1'b0, 1'b1}},
      '{'{OP_DRAW,  8'd128, 8'd64,  4'd0,  8'haa, 1'b1}, 1'b1, '{1'b0, 1'b0, 1'b1}},
      '{'{OP_READ,  8'd130, 8'd64,  4'd0,  8'h00, 1'b0}, 1'b0, '0},
      '{'{OP_DRAW,  8'd3,   8'd5,   4'd0,  8'h55, 1'b0}, 1'b0, '0},
      '{'{OP_DRAW,  8'd3,   8'd5,   4'd1,  8'hff, 1'b1}, 1'b0, '0}
    };

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    gap_pct = 33;
    for (int i = 0; i < N_DIR; i++) issue(dir_tab[i].cmd, dir_tab[i].fixed, dir_tab[i].res);

    for (int p = 0; p < N_PHASES; p++) begin
      settle();
      case (p)
        0: set_regs(1'b1, 7'd127, 6'd63);
        1: set_regs(1'b0, 7'd127, 6'd63);
        2: set_regs(1'b1, 7'd0, 6'd0);
        3: set_regs(1'b0, 7'($urandom_range(127)), 6'($urandom_range(63)));
        4: set_regs(1'b1, 7'($urandom_range(127)), 6'($urandom_range(63)));
        default: set_regs(1'b0, 7'd0, 6'd0);
      endcase
      gap_pct = (p < 2) ? 33 : (p < 4) ? 55 : 0;
      sent = 0;
      while (sent < RAND_ITEMS / N_PHASES) begin
        pick = $urandom_range(99);
        c = '0;
        c.x = 8'($urandom);
        c.y = 8'($urandom);
        c.row = 4'($urandom);
        c.bits = 8'($urandom);
        c.last = 1'($urandom);
        if (pick < 60) begin
          n = $urandom_range(16, 1);
          sp_x = c.x;
          sp_y = c.y;
          c.op = OP_DRAW;
          for (int r = 0; r < n; r++) begin
            c.row = 4'(r);
            c.bits = 8'($urandom);
            c.last = (r == n - 1);
            issue(c, 1'b0, '0);
            sent++;
          end
        end else begin
          if (pick < 72) begin
            c.op = OP_READ;
          end else if (pick < 85) begin
            c.op = OP_READ;
            c.x = sp_x + 8'($urandom_range(7));
            c.y = sp_y + 8'($urandom_range(15));
          end else if (pick < 87) begin
            c.op = OP_CLEAR;
          end else if (pick < 90) begin
            c.op = OP_NOP;
          end else begin
            c.op = OP_DRAW;
          end
          issue(c, 1'b0, '0);
          sent++;
        end
      end
    end

    settle();
    if (err_cnt == 0 && pending_res.size() == 0) begin
      $display("** sprite_xor_framebuffer_draw_core: PASSED **");
    end else begin
      $display("** sprite_xor_framebuffer_draw_core: FAILED **");
    end
    $finish;
  end

endmodule

[files.f]
+incdir+design
design/sxfd_pkg.sv
design/sxfd_addr.sv
design/sxfd_mem.sv
design/sprite_xor_framebuffer_draw_core.sv
tb/tb_sprite_xor_framebuffer_draw_core.sv
